[rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the integer matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

    // Default sizing of the engine.
    localparam int MAX_DIM_DEFAULT    = 8;
    localparam int ELEM_WIDTH_DEFAULT = 16;

    // Fixed widths of the stream fields.
    localparam int IDX_FIELD_W  = 3;
    localparam int VALUE_W      = 16;
    localparam int SUM_W        = 35;
    localparam int DIM_REG_W    = 4;
    localparam int CFG_INDEX_W  = 2;

    // Packed stream widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;
    localparam int S_TUSER_W = 2;

    // Reset value of the size registers.
    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    // Input word kinds carried in tuser.
    typedef enum logic [S_TUSER_W-1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_COMPUTE = 2'd2
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROWS_OF_A    = 2'd0,
        CFG_INNER_LENGTH = 2'd1,
        CFG_COLS_OF_B    = 2'd2
    } cfg_index_t;

    // Product sequencer states.
    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

endpackage : mme_pkg

`default_nettype wire

[rtl/mme_ram.sv]
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : mme_ram

`default_nettype wire

[rtl/matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Integer C = A x B: load words fill the A and B stores, a compute word
// streams out every element of C in row-major order through one shared MAC.
// ----------------------------------------------------------------------------
// Load words are accepted back to back while the engine is idle.
// A compute word issues one multiply-accumulate per cycle from the shared
// multiplier while the output is not stalled; each element passes the store
// read, the product register and the output register before it leaves.
// The input is not ready during the issue phase.
// Reset clears all control state and sets each size register to 8; the
// A and B stores keep no reset value and must be written before use.
`default_nettype none

module matrix_multiply_engine #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEFAULT,
    parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input words.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: row [2:0], col [5:3], value [21:6], zero pad [23:22]
    input  wire logic [mme_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: action [1:0]
    input  wire logic [mme_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // Result words.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: out_row [2:0], out_col [5:3], dot_sum [40:6], zero pad [47:41]
    output logic      [mme_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                    m_axis_tlast,
    // Configuration writes.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mme_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mme_pkg::DIM_REG_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VXW   = (ELEM_WIDTH > mme_pkg::VALUE_W) ? ELEM_WIDTH : mme_pkg::VALUE_W;
    localparam int PW    = 2 * ELEM_WIDTH;
    localparam int XW    = (PW > mme_pkg::SUM_W) ? PW : mme_pkg::SUM_W;

    // ------------------------------------------------------------------
    // Input word unpacking
    // ------------------------------------------------------------------
    logic [mme_pkg::IDX_FIELD_W-1:0] in_row;
    logic [mme_pkg::IDX_FIELD_W-1:0] in_col;
    logic signed [mme_pkg::VALUE_W-1:0] in_value;
    logic signed [VXW-1:0]           value_ext;
    logic [ELEM_WIDTH-1:0]           elem_data;
    logic                            in_fire;
    logic                            in_range;
    logic [AW-1:0]                   wr_addr;
    logic                            we_a;
    logic                            we_b;
    logic                            start;

    assign in_row    = s_axis_tdata[2:0];
    assign in_col    = s_axis_tdata[5:3];
    assign in_value  = s_axis_tdata[21:6];
    assign value_ext = VXW'(in_value);
    assign elem_data = value_ext[ELEM_WIDTH-1:0];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign in_range  = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign wr_addr   = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
    assign we_a      = in_fire && in_range && (s_axis_tuser == mme_pkg::ACT_WRITE_A);
    assign we_b      = in_fire && in_range && (s_axis_tuser == mme_pkg::ACT_WRITE_B);
    assign start     = in_fire && (s_axis_tuser == mme_pkg::ACT_COMPUTE);

    // ------------------------------------------------------------------
    // Size registers
    // ------------------------------------------------------------------
    logic [mme_pkg::DIM_REG_W-1:0] rows_reg;
    logic [mme_pkg::DIM_REG_W-1:0] inner_reg;
    logic [mme_pkg::DIM_REG_W-1:0] cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= mme_pkg::DIM_RESET;
            inner_reg <= mme_pkg::DIM_RESET;
            cols_reg  <= mme_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mme_pkg::CFG_ROWS_OF_A:    rows_reg  <= cfg_data;
                mme_pkg::CFG_INNER_LENGTH: inner_reg <= cfg_data;
                mme_pkg::CFG_COLS_OF_B:    cols_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Clamp a size register to 1..MAX_DIM and return the last index.
    function automatic logic [IDX_W-1:0] last_index(input logic [mme_pkg::DIM_REG_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(v - 1'b1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sequencer: walks i, j, k and, while the pipeline is not frozen, issues one store read pair per cycle
    // ------------------------------------------------------------------
    mme_pkg::seq_state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] ni_last_reg, ni_last_next;
    logic [IDX_W-1:0] nj_last_reg, nj_last_next;
    logic [IDX_W-1:0] nk_last_reg, nk_last_next;
    logic             adv;
    logic             issue;
    logic [AW-1:0]    rd_addr_a;
    logic [AW-1:0]    rd_addr_b;

    assign s_axis_tready = (state_reg == mme_pkg::SEQ_IDLE);
    assign issue         = (state_reg == mme_pkg::SEQ_RUN) && adv;
    assign rd_addr_a     = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign rd_addr_b     = AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mme_pkg::SEQ_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            ni_last_reg <= '0;
            nj_last_reg <= '0;
            nk_last_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            ni_last_reg <= ni_last_next;
            nj_last_reg <= nj_last_next;
            nk_last_reg <= nk_last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        ni_last_next = ni_last_reg;
        nj_last_next = nj_last_reg;
        nk_last_next = nk_last_reg;
        unique case (state_reg)
            mme_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next   = mme_pkg::SEQ_RUN;
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    ni_last_next = last_index(rows_reg);
                    nj_last_next = last_index(cols_reg);
                    nk_last_next = last_index(inner_reg);
                end
            end
            mme_pkg::SEQ_RUN:
            begin
                if (adv)
                begin
                    if (k_reg != nk_last_reg)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        k_next = '0;
                        if (j_reg != nj_last_reg)
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = '0;
                            if (i_reg != ni_last_reg)
                            begin
                                i_next = i_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = mme_pkg::SEQ_IDLE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = mme_pkg::SEQ_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Operand stores
    // ------------------------------------------------------------------
    logic [ELEM_WIDTH-1:0] a_data;
    logic [ELEM_WIDTH-1:0] b_data;

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (we_a),
        .waddr (wr_addr),
        .wdata (elem_data),
        .re    (adv),
        .raddr (rd_addr_a),
        .rdata (a_data)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (we_b),
        .waddr (wr_addr),
        .wdata (elem_data),
        .re    (adv),
        .raddr (rd_addr_b),
        .rdata (b_data)
    );

    // ------------------------------------------------------------------
    // Pipeline tags: read stage (s1) and product stage (s2)
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic             s1_first_reg;
    logic             s1_lastk_reg;
    logic             s1_last_reg;
    logic [IDX_W-1:0] s1_i_reg;
    logic [IDX_W-1:0] s1_j_reg;
    logic             s2_valid_reg;
    logic             s2_first_reg;
    logic             s2_lastk_reg;
    logic             s2_last_reg;
    logic [IDX_W-1:0] s2_i_reg;
    logic [IDX_W-1:0] s2_j_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;

    assign prod_next = $signed(a_data) * $signed(b_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_first_reg <= (k_reg == '0);
            s1_lastk_reg <= (k_reg == nk_last_reg);
            s1_last_reg  <= (i_reg == ni_last_reg) && (j_reg == nj_last_reg);
            s1_i_reg     <= i_reg;
            s1_j_reg     <= j_reg;
            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            s2_last_reg  <= s1_last_reg;
            s2_i_reg     <= s1_i_reg;
            s2_j_reg     <= s1_j_reg;
            prod_reg     <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Accumulator and output register
    // ------------------------------------------------------------------
    logic signed [XW-1:0]        prod_ext;
    logic [mme_pkg::SUM_W-1:0]   acc_reg;
    logic [mme_pkg::SUM_W-1:0]   sum;
    logic                        out_valid_reg;
    logic [mme_pkg::IDX_FIELD_W-1:0] out_row_reg;
    logic [mme_pkg::IDX_FIELD_W-1:0] out_col_reg;
    logic [mme_pkg::SUM_W-1:0]   out_sum_reg;
    logic                        out_last_reg;
    logic                        finish;

    assign prod_ext = XW'(prod_reg);
    assign sum      = (s2_first_reg ? '0 : acc_reg) + prod_ext[mme_pkg::SUM_W-1:0];
    assign finish   = s2_valid_reg && s2_lastk_reg;
    // The whole pipeline freezes while a finished element cannot be handed on.
    assign adv      = !(finish && out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && !s2_lastk_reg)
        begin
            acc_reg <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && finish)
        begin
            out_row_reg  <= mme_pkg::IDX_FIELD_W'(s2_i_reg);
            out_col_reg  <= mme_pkg::IDX_FIELD_W'(s2_j_reg);
            out_sum_reg  <= sum;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_sum_reg, out_col_reg, out_row_reg};

endmodule : matrix_multiply_engine

`default_nettype wire

[rtl/mme_checker.sv]
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [mme_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [mme_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    logic compute_fire;

    assign compute_fire = s_axis_tvalid && s_axis_tready &&
                          (s_axis_tuser == mme_pkg::ACT_COMPUTE);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // A compute word blocks the input for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        compute_fire |=> !s_axis_tready)
        else $error("input ready right after a compute word");

    // The input only stops accepting after a compute word was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(compute_fire))
        else $error("input ready fell without a compute word");

endmodule : mme_checker

bind matrix_multiply_engine mme_checker u_mme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
